// File: design/ghhd_pkg.sv
// Shared types and constants for the gyro heading hold drive block.
package ghhd_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxWidth = 3;
  localparam int unsigned CfgDataWidth = 20;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_BASE_SPEED  = 3'd0,
    CFG_RUN_TICKS   = 3'd1,
    CFG_BRAKE_TICKS = 3'd2,
    CFG_BIAS_Q4     = 3'd3,
    CFG_DEADBAND_Q4 = 3'd4,
    CFG_GAIN        = 3'd5
  } cfg_idx_e;

  // Register reset values
  localparam logic [18:0] DeadbandReset = 19'd262;
  localparam logic [15:0] GainReset = 16'd15345;

  // Product scale: accumulator is in Q4 counts, gain in 2^-24 steps
  localparam int unsigned GainShift = 28;

  // Drive phase held between ticks
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_RUN   = 2'd1,
    PH_BRAKE = 2'd2
  } phase_e;

  // What one tick produces, carried down the pipeline
  typedef enum logic [1:0] {
    KIND_IDLE  = 2'd0,
    KIND_RUN   = 2'd1,
    KIND_BRAKE = 2'd2,
    KIND_DONE  = 2'd3
  } kind_e;

endpackage

// File: design/gyro_heading_hold_drive_top.sv
// Gyro heading hold drive: tick sequencer, heading accumulator and steering datapath.
//
// Each accepted transaction is one control tick and yields exactly one result
// transaction, registered through stages 1 to 5 and then the output register.
// A new tick can be accepted every cycle that stage 1 can load (in_ready_o):
// the phase/tick-count update and the heading accumulator update each take one
// pipeline stage, so a tick sees the state left by the one before it. The
// steering multiply (|heading| x gain) and the final saturating wheel sums sit
// in later stages; stages hold and bubbles close up independently, so input is
// taken while a finished result waits. Configuration writes are registered
// directly and should be made only while no tick is in flight.
module gyro_heading_hold_drive_top #(
  parameter int unsigned ACC_WIDTH = 40
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write port
  input  logic                            cfg_we_i,
  input  logic [ghhd_pkg::CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [ghhd_pkg::CfgDataWidth-1:0] cfg_wdata_i,
  // tick input
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [15:0]              gyro_z_i,
  input  logic                            start_req_i,
  // result output
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [15:0]              left_speed_o,
  output logic signed [15:0]              right_speed_o,
  output logic                            busy_res_o,
  output logic                            done_res_o
);
  import ghhd_pkg::*;

  localparam int unsigned ProdWidth = ACC_WIDTH + 16;
  localparam logic signed [ACC_WIDTH-1:0] AccMax = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] AccMin = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  // Saturate an 18-bit signed value to 16 bits
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // ---------------------------------------------------------------- config
  logic signed [15:0] base_speed_q;
  logic [15:0]        run_ticks_q;
  logic [15:0]        brake_ticks_q;
  logic signed [19:0] bias_q4_q;
  logic [18:0]        deadband_q4_q;
  logic [15:0]        gain_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_speed_q  <= '0;
      run_ticks_q   <= '0;
      brake_ticks_q <= '0;
      bias_q4_q     <= '0;
      deadband_q4_q <= DeadbandReset;
      gain_q        <= GainReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_BASE_SPEED:  base_speed_q  <= cfg_wdata_i[15:0];
        CFG_RUN_TICKS:   run_ticks_q   <= cfg_wdata_i[15:0];
        CFG_BRAKE_TICKS: brake_ticks_q <= cfg_wdata_i[15:0];
        CFG_BIAS_Q4:     bias_q4_q     <= cfg_wdata_i[19:0];
        CFG_DEADBAND_Q4: deadband_q4_q <= cfg_wdata_i[18:0];
        CFG_GAIN:        gain_q        <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------- flow control
  logic v1_q, v2_q, v3_q, v4_q, v5_q, vo_q;
  logic en1, en2, en3, en4, en5, en_o;

  // A stage loads when it is empty or its item moves on
  assign en_o = ~vo_q | out_ready_i;
  assign en5  = ~v5_q | en_o;
  assign en4  = ~v4_q | en5;
  assign en3  = ~v3_q | en4;
  assign en2  = ~v2_q | en3;
  assign en1  = ~v1_q | en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1)  v1_q <= in_valid_i;
      if (en2)  v2_q <= v1_q;
      if (en3)  v3_q <= v2_q;
      if (en4)  v4_q <= v3_q;
      if (en5)  v5_q <= v4_q;
      if (en_o) vo_q <= v5_q;
    end
  end

  // ------------------------------------------------------ stage 1: input
  logic signed [15:0] gz1_q;
  logic               start1_q;

  always_ff @(posedge clk_i) begin
    if (en1) begin
      gz1_q    <= gyro_z_i;
      start1_q <= start_req_i;
    end
  end

  // ------------------------------------- stage 1 -> 2: sequencer and bias
  phase_e      phase_q, phase_d;
  logic [15:0] tick_q, tick_d;
  logic        step;
  logic        is_idle, run_entry, run_go, brake_entry, brake_go;
  logic [15:0] run_t, brake_t;
  kind_e       kind_d;
  logic        clr_d;

  assign step = v1_q & en2;

  // Work out which phase this tick falls in
  assign is_idle     = (phase_q != PH_RUN) && (phase_q != PH_BRAKE);
  assign run_entry   = (phase_q == PH_RUN) || (is_idle && start1_q);
  assign run_t       = (phase_q == PH_RUN) ? tick_q : '0;
  assign run_go      = run_entry && (run_t < run_ticks_q);
  assign brake_entry = (phase_q == PH_BRAKE) || (run_entry && !run_go);
  assign brake_t     = (phase_q == PH_BRAKE) ? tick_q : '0;
  assign brake_go    = brake_entry && (brake_t < brake_ticks_q);

  // Next phase and tick count
  always_comb begin
    phase_d = PH_IDLE;
    tick_d  = '0;
    if (run_go) begin
      phase_d = PH_RUN;
      tick_d  = run_t + 16'd1;
    end else if (brake_go) begin
      phase_d = PH_BRAKE;
      tick_d  = brake_t + 16'd1;
    end else if (!brake_entry) begin
      phase_d = PH_IDLE;
      tick_d  = tick_q;
    end
  end

  // Tick kind and accumulator clear
  always_comb begin
    clr_d = is_idle && start1_q;
    if (run_go) begin
      kind_d = KIND_RUN;
    end else if (brake_go) begin
      kind_d = KIND_BRAKE;
    end else if (brake_entry) begin
      kind_d = KIND_DONE;
    end else begin
      kind_d = KIND_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      tick_q  <= '0;
    end else if (step) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
    end
  end

  // Bias-correct the sample and test it against the deadband
  logic signed [20:0] d_s;
  logic [20:0]        d_mag;
  logic               take_d;

  assign d_s    = 21'($signed({gz1_q, 4'b0000})) - 21'(bias_q4_q);
  assign d_mag  = d_s[20] ? 21'(-d_s) : 21'(d_s);
  assign take_d = d_mag > {2'b00, deadband_q4_q};

  kind_e              kind2_q;
  logic               clr2_q;
  logic               take2_q;
  logic signed [20:0] d2_q;

  always_ff @(posedge clk_i) begin
    if (en2) begin
      kind2_q <= kind_d;
      clr2_q  <= clr_d;
      take2_q <= take_d;
      d2_q    <= d_s;
    end
  end

  // ------------------------------------- stage 2 -> 3: heading accumulator
  logic signed [ACC_WIDTH-1:0] acc_q, acc_d;
  logic signed [ACC_WIDTH-1:0] acc_base;
  logic signed [ACC_WIDTH:0]   acc_sum;
  logic                        acc_upd;

  assign acc_upd  = v2_q & en3 & ((kind2_q == KIND_RUN) | clr2_q);
  assign acc_base = clr2_q ? '0 : acc_q;
  assign acc_sum  = {acc_base[ACC_WIDTH-1], acc_base}
                  + (take2_q ? {{(ACC_WIDTH-20){d2_q[20]}}, d2_q} : '0);

  // Saturate the sum to the accumulator range
  always_comb begin
    if (acc_sum[ACC_WIDTH] != acc_sum[ACC_WIDTH-1]) begin
      acc_d = acc_sum[ACC_WIDTH] ? AccMin : AccMax;
    end else begin
      acc_d = acc_sum[ACC_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (acc_upd) begin
      acc_q <= acc_d;
    end
  end

  kind_e                       kind3_q;
  logic signed [ACC_WIDTH-1:0] acc3_q;

  always_ff @(posedge clk_i) begin
    if (en3) begin
      kind3_q <= kind2_q;
      acc3_q  <= acc_d;
    end
  end

  // -------------------------------------------- stage 3 -> 4: magnitude
  kind_e                kind4_q;
  logic                 pos4_q;
  logic [ACC_WIDTH-1:0] mag4_q;

  always_ff @(posedge clk_i) begin
    if (en4) begin
      kind4_q <= kind3_q;
      pos4_q  <= (acc3_q > 0);
      mag4_q  <= acc3_q[ACC_WIDTH-1] ? ACC_WIDTH'(-acc3_q) : ACC_WIDTH'(acc3_q);
    end
  end

  // --------------------------------------------- stage 4 -> 5: multiply
  kind_e                kind5_q;
  logic                 pos5_q;
  logic [ProdWidth-1:0] prod5_q;

  always_ff @(posedge clk_i) begin
    if (en5) begin
      kind5_q <= kind4_q;
      pos5_q  <= pos4_q;
      prod5_q <= ProdWidth'(mag4_q) * ProdWidth'(gain_q);
    end
  end

  // ------------------------------------- stage 5 -> out: steer and brake
  logic [ProdWidth-1:0] p_full;
  logic [16:0]          p17;
  logic signed [16:0]   adj17;
  logic signed [15:0]   adj16;
  logic signed [15:0]   brake_val;
  logic signed [15:0]   left_d, right_d;
  logic                 busy_d, done_d;

  // Scale the product and clamp the correction to 16 bits
  assign p_full = prod5_q >> GainShift;
  assign p17    = (p_full > ProdWidth'(32768)) ? 17'd32768 : p_full[16:0];
  assign adj17  = pos5_q ? -$signed(p17) : $signed(p17);
  assign adj16  = (adj17 == 17'sd32768) ? 16'sh7fff : adj17[15:0];

  assign brake_val = (base_speed_q == 16'sh8000) ? 16'sh7fff : -base_speed_q;

  // Select the wheel values for this tick
  always_comb begin
    left_d  = '0;
    right_d = '0;
    busy_d  = 1'b0;
    done_d  = 1'b0;
    case (kind5_q)
      KIND_RUN: begin
        left_d  = sat16(18'(base_speed_q) - 18'(adj16));
        right_d = sat16(18'(base_speed_q) + 18'(adj16));
        busy_d  = 1'b1;
      end
      KIND_BRAKE: begin
        left_d  = brake_val;
        right_d = brake_val;
        busy_d  = 1'b1;
      end
      KIND_DONE: begin
        done_d = 1'b1;
      end
      default: ;
    endcase
  end

  logic signed [15:0] left_q, right_q;
  logic               busy_q, done_q;

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      left_q  <= left_d;
      right_q <= right_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
    end
  end

  assign out_valid_o   = vo_q;
  assign left_speed_o  = left_q;
  assign right_speed_o = right_q;
  assign busy_res_o    = busy_q;
  assign done_res_o    = done_q;

endmodule

// File: design/ghhd_chk.sv
// Port-level checker for the gyro heading hold drive, bound to the top level.
module ghhd_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [15:0] left_speed_o,
  input logic signed [15:0] right_speed_o,
  input logic               busy_res_o,
  input logic               done_res_o
);

  // A result is never both busy and done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(busy_res_o && done_res_o))
    else $error("busy and done both set on a result");

  // The stop tick drives both wheels to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |-> (left_speed_o == 16'sd0 && right_speed_o == 16'sd0))
    else $error("done result with nonzero speed");

  // Outside a drive the wheels stay stopped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !busy_res_o) |-> (left_speed_o == 16'sd0 && right_speed_o == 16'sd0))
    else $error("idle result with nonzero speed");

  // A stalled result transaction holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(left_speed_o)
      && $stable(right_speed_o) && $stable(busy_res_o) && $stable(done_res_o)))
    else $error("stalled result changed");

endmodule

bind gyro_heading_hold_drive_top ghhd_chk u_ghhd_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .left_speed_o  (left_speed_o),
  .right_speed_o (right_speed_o),
  .busy_res_o    (busy_res_o),
  .done_res_o    (done_res_o)
);
